// ===== hw/rtl/spd_pkg.sv =====
// Shared types and constants for the sequenced packet deframer.
package spd_pkg;

  // Length value that marks a packet as continuing the message
  localparam logic [23:0] MAX_CHUNK_LENGTH = 24'hFFFFFF;

  // Queue between header parser and result stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Parser phase
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DISCARD = 2'd2
  } phase_t;

  // Command passed from the parser to the result stage
  typedef enum logic [2:0] {
    OP_PAYLOAD     = 3'd0,  // plain payload byte
    OP_PAYLOAD_END = 3'd1,  // last payload byte of a message
    OP_HEADER      = 3'd2,  // good header with nonzero length, no result
    OP_EMPTY_END   = 3'd3,  // good header with zero length, ends message
    OP_SEQ_ERR     = 3'd4   // sequence mismatch, restarts message
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  data;  // payload byte or header sequence byte
    logic [23:0] len;   // packet length for OP_HEADER
  } cmd_t;

endpackage

// ===== hw/rtl/sequenced_packet_deframer.sv =====
// Top level of the sequenced packet deframer.
//
// Input channel: one link byte per request (stream_byte, in_valid, in_stall).
// Each packet is a 4-byte header (24-bit little-endian length, then a
// sequence byte) followed by that many payload bytes.
// Output channel: one result per request (out_valid, out_stall): payload
// bytes, message end with the saturated message length, or a sequence error.
// Header length bytes, the sequence byte of a good nonempty packet and
// discarded payload give no result. Throughput: one byte per cycle while
// the receiver does not stall. An accepted byte passes first through the
// command queue, then through the result register.
// A 4-entry command queue decouples the parser from the output register;
// when the receiver stalls, the queue fills and in_stall rises once it is
// full. Nothing is lost or repeated across stalls.
// Reset (rst, synchronous) returns the parser to header phase with the
// expected sequence at one, clears totals, queue and output valid.
module sequenced_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  stream_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  payload_byte,
  output logic        has_payload,
  output logic        message_end,
  output logic [31:0] message_length,
  output logic        sequence_error,
  output logic [7:0]  received_sequence
);
  import spd_pkg::*;

  logic q_push, q_full, q_pop, q_empty;
  cmd_t push_cmd, head_cmd;

  spd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .stream_byte (stream_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_cmd       (push_cmd)
  );

  spd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_cmd (head_cmd)
  );

  spd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_empty           (q_empty),
    .q_cmd             (head_cmd),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .payload_byte      (payload_byte),
    .has_payload       (has_payload),
    .message_end       (message_end),
    .message_length    (message_length),
    .sequence_error    (sequence_error),
    .received_sequence (received_sequence)
  );

endmodule

// ===== hw/rtl/spd_front.sv =====
// Header parser: tracks framing and sequence, turns bytes into commands.
module spd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    stream_byte,
  input  logic          q_full,
  output logic          q_push,
  output spd_pkg::cmd_t q_cmd
);
  import spd_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  header_index, header_index_next;
  logic [23:0] length_accumulator, length_accumulator_next;
  logic [23:0] bytes_remaining, bytes_remaining_next;
  logic [7:0]  expected_sequence, expected_sequence_next;
  logic        final_packet, final_packet_next;

  logic        accept;
  logic [23:0] rem_dec;
  logic        seq_match;

  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;
  assign rem_dec   = bytes_remaining - 24'd1;
  assign seq_match = (stream_byte == expected_sequence);

  // Phase transitions
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_PAYLOAD, PH_DISCARD: begin
          if (rem_dec == 24'd0) phase_next = PH_HEADER;
        end
        default: begin
          phase_next = PH_HEADER;
          if (header_index == 2'd3) begin
            if (length_accumulator != 24'd0) begin
              phase_next = seq_match ? PH_PAYLOAD : PH_DISCARD;
            end
          end
        end
      endcase
    end
  end

  // Counters, header assembly and command generation
  always_comb begin
    header_index_next       = header_index;
    length_accumulator_next = length_accumulator;
    bytes_remaining_next    = bytes_remaining;
    expected_sequence_next  = expected_sequence;
    final_packet_next       = final_packet;
    q_push                  = 1'b0;
    q_cmd.op                = OP_PAYLOAD;
    q_cmd.data              = stream_byte;
    q_cmd.len               = length_accumulator;
    if (accept) begin
      unique case (phase)
        PH_PAYLOAD: begin
          bytes_remaining_next = rem_dec;
          q_push               = 1'b1;
          if (rem_dec == 24'd0 && final_packet) begin
            // last byte of the final packet starts a new message
            q_cmd.op               = OP_PAYLOAD_END;
            expected_sequence_next = 8'd1;
          end
        end
        PH_DISCARD: begin
          bytes_remaining_next = rem_dec;
        end
        default: begin
          if (header_index != 2'd3) begin
            // little-endian length bytes
            case (header_index)
              2'd0:    length_accumulator_next[7:0]   = stream_byte;
              2'd1:    length_accumulator_next[15:8]  = stream_byte;
              default: length_accumulator_next[23:16] = stream_byte;
            endcase
            header_index_next = header_index + 2'd1;
          end else begin
            header_index_next       = 2'd0;
            length_accumulator_next = 24'd0;
            q_push                  = 1'b1;
            if (!seq_match) begin
              q_cmd.op               = OP_SEQ_ERR;
              expected_sequence_next = 8'd1;
              final_packet_next      = 1'b0;
              bytes_remaining_next   = length_accumulator;
            end else begin
              expected_sequence_next = expected_sequence + 8'd1;
              if (length_accumulator == 24'd0) begin
                // empty packet ends the message at once
                q_cmd.op               = OP_EMPTY_END;
                final_packet_next      = 1'b0;
                expected_sequence_next = 8'd1;
              end else begin
                q_cmd.op             = OP_HEADER;
                final_packet_next    = (length_accumulator != MAX_CHUNK_LENGTH);
                bytes_remaining_next = length_accumulator;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_HEADER;
      header_index       <= 2'd0;
      length_accumulator <= 24'd0;
      bytes_remaining    <= 24'd0;
      expected_sequence  <= 8'd1;
      final_packet       <= 1'b0;
    end else begin
      phase              <= phase_next;
      header_index       <= header_index_next;
      length_accumulator <= length_accumulator_next;
      bytes_remaining    <= bytes_remaining_next;
      expected_sequence  <= expected_sequence_next;
      final_packet       <= final_packet_next;
    end
  end

  // A mismatch restarts the sequence at one
  a_err_restart: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_cmd.op == OP_SEQ_ERR) |=> (expected_sequence == 8'd1))
    else $error("sequence not restarted after mismatch");

  // Header assembly only happens in header phase
  a_idx_phase: assert property (@(posedge clk) disable iff (rst)
    (header_index != 2'd0) |-> (phase != PH_PAYLOAD && phase != PH_DISCARD))
    else $error("header index set outside header phase");

endmodule

// ===== hw/rtl/spd_queue.sv =====
// Small command queue between the parser and the result stage.
module spd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output spd_pkg::cmd_t head_cmd
);
  import spd_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full     = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Fill count never exceeds the depth
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count out of range");

endmodule

// ===== hw/rtl/spd_back.sv =====
// Result stage: keeps message totals and registers one result for output.
module spd_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  spd_pkg::cmd_t q_cmd,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    payload_byte,
  output logic          has_payload,
  output logic          message_end,
  output logic [31:0]   message_length,
  output logic          sequence_error,
  output logic [7:0]    received_sequence
);
  import spd_pkg::*;

  logic [31:0] message_total;
  logic [7:0]  last_sequence;
  logic [32:0] sum;
  logic [31:0] sat_total;
  logic        makes_result;

  assign sum          = {1'b0, message_total} + {9'd0, q_cmd.len};
  assign sat_total    = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign makes_result = (q_cmd.op != OP_HEADER);
  assign q_pop        = !q_empty && (!makes_result || !out_valid || !out_stall);

  // Running total and sequence of the latest header
  always_ff @(posedge clk) begin
    if (rst) begin
      message_total <= 32'd0;
      last_sequence <= 8'd0;
    end else if (q_pop) begin
      unique case (q_cmd.op)
        OP_HEADER: begin
          last_sequence <= q_cmd.data;
          message_total <= sat_total;
        end
        OP_EMPTY_END, OP_SEQ_ERR: begin
          last_sequence <= q_cmd.data;
          message_total <= 32'd0;
        end
        OP_PAYLOAD_END: message_total <= 32'd0;
        default:        message_total <= message_total;
      endcase
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop && makes_result) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (q_pop && makes_result) begin
      payload_byte      <= 8'd0;
      has_payload       <= 1'b0;
      message_end       <= 1'b0;
      message_length    <= 32'd0;
      sequence_error    <= 1'b0;
      received_sequence <= last_sequence;
      unique case (q_cmd.op)
        OP_PAYLOAD: begin
          payload_byte <= q_cmd.data;
          has_payload  <= 1'b1;
        end
        OP_PAYLOAD_END: begin
          payload_byte   <= q_cmd.data;
          has_payload    <= 1'b1;
          message_end    <= 1'b1;
          message_length <= message_total;
        end
        OP_EMPTY_END: begin
          message_end       <= 1'b1;
          message_length    <= message_total;
          received_sequence <= q_cmd.data;
        end
        default: begin
          sequence_error    <= 1'b1;
          received_sequence <= q_cmd.data;
        end
      endcase
    end
  end

  // An error result never carries data or ends a message
  a_err_alone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sequence_error) |-> (!has_payload && !message_end))
    else $error("error result carries payload or end");

  // Total is cleared after a payload message end or a sequence error leaves the queue
  a_total_clear: assert property (@(posedge clk) disable iff (rst)
    (q_pop && (q_cmd.op == OP_PAYLOAD_END || q_cmd.op == OP_SEQ_ERR))
      |=> (message_total == 32'd0))
    else $error("message total not cleared");

endmodule

// ===== bench/spd_checker.sv =====
// Checker for the packet deframer: predicts results from accepted link bytes and compares them.
module spd_checker
  import spd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  stream_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  payload_byte,
  input  logic        has_payload,
  input  logic        message_end,
  input  logic [31:0] message_length,
  input  logic        sequence_error,
  input  logic [7:0]  received_sequence,
  output int          mismatches,
  output int          outstanding,
  output int          results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        has_payload;
    logic        message_end;
    logic [31:0] message_length;
    logic        sequence_error;
    logic [7:0]  received_sequence;
  } frame_result_t;

  localparam int PRINT_CAP = 30;

  // Expected results, oldest first
  frame_result_t expected_q[$];

  // Deframer state as the checker tracks it
  phase_t      ph;
  logic [1:0]  hdr_pos;
  logic [23:0] len_acc;
  logic [23:0] remaining;
  logic [7:0]  want_seq;
  logic [7:0]  last_seq;
  logic [31:0] total;
  logic        closing;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("%0t spd_checker: %s", $realtime, what);
  endtask

  // Advance the deframer by one link byte and queue what it should emit
  task automatic deframe_byte(input logic [7:0] b);
    frame_result_t r;
    logic [23:0]   plen;
    logic [32:0]   sum;
    r = '0;
    case (ph)
      PH_PAYLOAD: begin
        remaining = remaining - 24'd1;
        r.payload_byte = b;
        r.has_payload = 1'b1;
        r.received_sequence = last_seq;
        if (remaining == 24'd0) begin
          ph = PH_HEADER;
          if (closing) begin
            r.message_end = 1'b1;
            r.message_length = total;
            want_seq = 8'd1;
            total = '0;
          end
        end
        expected_q.push_back(r);
      end
      PH_DISCARD: begin
        remaining = remaining - 24'd1;
        if (remaining == 24'd0)
          ph = PH_HEADER;
      end
      default: begin
        ph = PH_HEADER;
        if (hdr_pos != 2'd3) begin
          // length bytes, little endian
          len_acc = len_acc | ({16'd0, b} << (8 * hdr_pos));
          hdr_pos = hdr_pos + 2'd1;
        end else begin
          hdr_pos = '0;
          last_seq = b;
          plen = len_acc;
          len_acc = '0;
          r.received_sequence = b;
          if (b != want_seq) begin
            // bad sequence: flag it, drop the payload, restart the message
            want_seq = 8'd1;
            total = '0;
            closing = 1'b0;
            remaining = plen;
            ph = (plen != 24'd0) ? PH_DISCARD : PH_HEADER;
            r.sequence_error = 1'b1;
            expected_q.push_back(r);
          end else begin
            want_seq = want_seq + 8'd1;
            closing = (plen != MAX_CHUNK_LENGTH);
            sum = {1'b0, total} + {9'd0, plen};
            total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            if (plen == 24'd0) begin
              // empty packet closes the message right away
              r.message_end = 1'b1;
              r.message_length = total;
              expected_q.push_back(r);
              want_seq = 8'd1;
              total = '0;
              closing = 1'b0;
            end else begin
              remaining = plen;
              ph = PH_PAYLOAD;
            end
          end
        end
      end
    endcase
  endtask

  // Compare one delivered result with the oldest expectation
  task automatic check_result();
    frame_result_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result, payload_byte %02h message_end %0b",
                                payload_byte, message_end));
    end else begin
      want = expected_q.pop_front();
      if (payload_byte !== want.payload_byte)
        report_mismatch($sformatf("result %0d payload_byte %02h, want %02h",
                                  results_checked, payload_byte, want.payload_byte));
      if (has_payload !== want.has_payload)
        report_mismatch($sformatf("result %0d has_payload %0b, want %0b",
                                  results_checked, has_payload, want.has_payload));
      if (message_end !== want.message_end)
        report_mismatch($sformatf("result %0d message_end %0b, want %0b",
                                  results_checked, message_end, want.message_end));
      if (message_length !== want.message_length)
        report_mismatch($sformatf("result %0d message_length %0d, want %0d",
                                  results_checked, message_length, want.message_length));
      if (sequence_error !== want.sequence_error)
        report_mismatch($sformatf("result %0d sequence_error %0b, want %0b",
                                  results_checked, sequence_error, want.sequence_error));
      if (received_sequence !== want.received_sequence)
        report_mismatch($sformatf("result %0d received_sequence %02h, want %02h",
                                  results_checked, received_sequence,
                                  want.received_sequence));
    end
    results_checked++;
  endtask

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      ph = PH_HEADER;
      hdr_pos = '0;
      len_acc = '0;
      remaining = '0;
      want_seq = 8'd1;
      last_seq = '0;
      total = '0;
      closing = 1'b0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall)
        check_result();
      if (in_valid && !in_stall)
        deframe_byte(stream_byte);
    end
    outstanding = expected_q.size();
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the deframer testbench: clock, reset, packet stimulus, flow control and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import spd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BYTES = 300;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  stream_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  payload_byte;
  logic        has_payload;
  logic        message_end;
  logic [31:0] message_length;
  logic        sequence_error;
  logic [7:0]  received_sequence;

  int mismatches;
  int outstanding;
  int results_checked;

  // Flow control knobs, in percent of cycles
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;

  // Stimulus bookkeeping
  logic [7:0]  next_seq;
  logic [7:0]  preset_bytes[$];
  int unsigned bytes_sent;
  int unsigned packets_sent;
  int unsigned bad_seq_packets;
  int unsigned quiet_cycles;

  sequenced_packet_deframer DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .stream_byte       (stream_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .payload_byte      (payload_byte),
    .has_payload       (has_payload),
    .message_end       (message_end),
    .message_length    (message_length),
    .sequence_error    (sequence_error),
    .received_sequence (received_sequence)
  );

  spd_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .stream_byte       (stream_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .payload_byte      (payload_byte),
    .has_payload       (has_payload),
    .message_end       (message_end),
    .message_length    (message_length),
    .sequence_error    (sequence_error),
    .received_sequence (received_sequence),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .results_checked   (results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls at random, decided at each falling edge
  always @(negedge clk) begin
    out_stall <= rst ? 1'b0 : ($urandom_range(99) < sink_stall_pct);
  end

  // Watchdog: ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one link byte, with random idle cycles ahead of it; entered at a falling edge
  task automatic send_link_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  // Header then payload; preset bytes go first, the rest is random
  task automatic send_packet(input logic [23:0] len, input logic [7:0] seq);
    int unsigned i;
    send_link_byte(len[7:0]);
    send_link_byte(len[15:8]);
    send_link_byte(len[23:16]);
    send_link_byte(seq);
    if (seq != next_seq) begin
      bad_seq_packets++;
      next_seq = 8'd1;
    end else if (len == MAX_CHUNK_LENGTH) begin
      next_seq = next_seq + 8'd1;
    end else begin
      next_seq = 8'd1;
    end
    for (i = 0; i < len; i++)
      send_link_byte((i < preset_bytes.size()) ? preset_bytes[i] : 8'($urandom));
    preset_bytes.delete();
    packets_sent++;
  endtask

  // Mostly well-formed short packets, some empty, some with a wrong sequence byte
  task automatic send_random_packet();
    logic [23:0] len;
    logic [7:0]  seq;
    len = ($urandom_range(99) < 15) ? 24'd0 : 24'($urandom_range(1, 12));
    if ($urandom_range(9) == 0)
      len = 24'($urandom_range(13, 60));
    seq = next_seq;
    if ($urandom_range(9) < 2)
      seq = next_seq ^ 8'($urandom_range(1, 255));
    send_packet(len, seq);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    stream_byte = '0;
    out_stall = 1'b0;
    src_idle_pct = 20;
    sink_stall_pct = 53;
    next_seq = 8'd1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty message, byte extremes, bad sequence with and without payload
    send_packet(24'd0, 8'd1);
    preset_bytes = '{8'h00, 8'hFF, 8'h5A};
    send_packet(24'd3, 8'd1);
    send_packet(24'd2, 8'hFF);
    send_packet(24'd0, 8'h00);
    preset_bytes = '{8'hA5};
    send_packet(24'd1, 8'd1);

    // Random traffic in three flow-control settings
    while (bytes_sent < PHASE_BYTES)
      send_random_packet();
    src_idle_pct = 53;
    sink_stall_pct = 20;
    while (bytes_sent < 2 * PHASE_BYTES)
      send_random_packet();
    src_idle_pct = 0;
    sink_stall_pct = 0;
    while (bytes_sent < 3 * PHASE_BYTES)
      send_random_packet();

    in_valid <= 1'b0;
    while (outstanding != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run covered %0d link bytes in %0d packets, %0d with a wrong sequence byte,",
             bytes_sent, packets_sent, bad_seq_packets);
    $display("under three flow-control mixes; %0d results checked, %0d mismatches",
             results_checked, mismatches);
    if (mismatches == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
